/* hdl/tfn_pkg.sv */
// shared widths, constants and pipeline payload types of the triangle face normal block
package tfn_pkg;

   localparam int COORD_WIDTH      = 24;
   localparam int NORMAL_FRAC_BITS = 14;
   localparam int NORMAL_WIDTH     = NORMAL_FRAC_BITS + 2;

   localparam int EDGE_WIDTH  = COORD_WIDTH + 1;
   localparam int PROD_WIDTH  = 2 * EDGE_WIDTH;
   localparam int CROSS_WIDTH = PROD_WIDTH + 1;

   localparam int MIN_LENGTH_WIDTH = 40;
   localparam logic [MIN_LENGTH_WIDTH-1:0] MIN_LENGTH_RESET = MIN_LENGTH_WIDTH'(168);
   localparam int HALF_WIDTH = MIN_LENGTH_WIDTH / 2;
   localparam int SQ_WIDTH   = 2 * MIN_LENGTH_WIDTH;
   localparam int L2_WIDTH   = SQ_WIDTH + 2;

   localparam int NORM_TOP_BITS = 30;
   localparam int SUM_WIDTH     = 2 * NORM_TOP_BITS + 2;
   localparam int ROOT_WIDTH    = NORM_TOP_BITS + 1;
   localparam int REM_WIDTH     = ROOT_WIDTH + 2;

   localparam int QUOT_WIDTH = NORMAL_FRAC_BITS + 1;
   localparam int NUM_WIDTH  = NORM_TOP_BITS + NORMAL_FRAC_BITS + 2;
   localparam int DIV_WIDTH  = ROOT_WIDTH + 1;

   localparam int SHIFT_WIDTH  = (CROSS_WIDTH > NORM_TOP_BITS) ? CROSS_WIDTH : NORM_TOP_BITS;
   localparam int BITLEN_WIDTH = $clog2(SHIFT_WIDTH + 1);
   localparam int GROUPS       = (CROSS_WIDTH + 7) / 8;

   localparam int REQ_DATA_WIDTH = ((9 * COORD_WIDTH + 7) / 8) * 8;
   localparam int RSP_DATA_WIDTH = ((3 * NORMAL_WIDTH + 7) / 8) * 8;

   typedef struct packed {
      logic [2:0][NORM_TOP_BITS-1:0] a;
      logic [2:0]                    neg;
      logic                          degen;
   } root_side_type;

   typedef struct packed {
      logic [2:0] neg;
      logic       degen;
   } div_side_type;

endpackage

/* hdl/triangle_face_normal_top.sv */
// top level of the triangle face normal pipeline
//
//   channel  direction  handshake            payload
//   req      in         req_tvalid/tready    req_tdata: ax ay az bx by_coord bz cx cy cz
//   rsp      out        rsp_tvalid/tready    rsp_tdata: nx ny nz, rsp_tuser: degenerate
//   csr      in         csr_valid/ready      csr_data: min_length
//
// one transaction per cycle sustained while rsp_tready stays high; registered stages from req to rsp register
// (4 cross product, 6 normalize, 31 square root steps, 15 divide steps, 1 output)
// reset clears every stage valid bit and loads min_length with 168
// ready ripples back stage by stage, so a stalled rsp only fills the empty stages
// and bubbles get squeezed out; nothing is dropped or duplicated
module triangle_face_normal_top (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // ax, ay, az, bx, by_coord, bz, cx, cy, cz from bit 0 up
   input  logic [tfn_pkg::REQ_DATA_WIDTH-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // nx, ny, nz from bit 0 up, zero padded
   output logic [tfn_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   // degenerate
   output logic [0:0] rsp_tuser,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [tfn_pkg::MIN_LENGTH_WIDTH-1:0] csr_data
);

   localparam int HW  = tfn_pkg::HALF_WIDTH;
   localparam int NWD = tfn_pkg::NORMAL_WIDTH;
   localparam int QW  = tfn_pkg::QUOT_WIDTH;
   localparam logic [QW-1:0] Q_ONE = QW'(1) << tfn_pkg::NORMAL_FRAC_BITS;

   // threshold register and its square, recomputed through the partial product and square registers after a write
   logic [tfn_pkg::MIN_LENGTH_WIDTH-1:0] min_length_ff;
   logic [2*HW-1:0] ml_hh_ff, ml_hl_ff, ml_ll_ff;
   logic [tfn_pkg::SQ_WIDTH-1:0] ml_sq_ff, ml_sq_in;

   logic [8:0][tfn_pkg::COORD_WIDTH-1:0] coord;

   // stage to stage handshakes
   logic cross_valid, cross_ready, norm_valid, norm_ready;
   logic root_valid, root_ready, div_valid, div_ready;
   logic [2:0][tfn_pkg::CROSS_WIDTH-1:0] cross_mag;
   logic [2:0] cross_neg;
   tfn_pkg::root_side_type norm_side, root_side;
   logic [tfn_pkg::SUM_WIDTH-1:0] norm_sum;
   logic [tfn_pkg::ROOT_WIDTH-1:0] root;
   logic [2:0][QW-1:0] quot;
   tfn_pkg::div_side_type div_side;

   // output register
   logic rsp_valid_ff;
   logic [tfn_pkg::RSP_DATA_WIDTH-1:0] rsp_data_ff, rsp_data_in;
   logic rsp_user_ff;
   logic out_ready;
   logic [QW-1:0] qs;
   logic [NWD-1:0] comp;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_length_ff <= tfn_pkg::MIN_LENGTH_RESET;
      end else if (csr_valid && csr_ready) begin
         min_length_ff <= csr_data;
      end
   end

   // split squaring keeps each multiplier at half width
   assign ml_sq_in = (tfn_pkg::SQ_WIDTH'(ml_hh_ff) << (2*HW))
                   + (tfn_pkg::SQ_WIDTH'(ml_hl_ff) << (HW + 1))
                   + tfn_pkg::SQ_WIDTH'(ml_ll_ff);

   always_ff @(posedge clock) begin
      ml_hh_ff <= min_length_ff[2*HW-1:HW] * min_length_ff[2*HW-1:HW];
      ml_hl_ff <= min_length_ff[2*HW-1:HW] * min_length_ff[HW-1:0];
      ml_ll_ff <= min_length_ff[HW-1:0] * min_length_ff[HW-1:0];
      ml_sq_ff <= ml_sq_in;
   end

   // unpack the nine corner coordinates
   always_comb begin
      for (int i = 0; i < 9; i++) coord[i] = req_tdata[i*tfn_pkg::COORD_WIDTH +: tfn_pkg::COORD_WIDTH];
   end

   tfn_cross u_cross (
      .clock(clock), .reset(reset),
      .up_valid(req_tvalid), .up_ready(req_tready), .up_coord(coord),
      .dn_valid(cross_valid), .dn_ready(cross_ready),
      .dn_mag(cross_mag), .dn_neg(cross_neg)
   );

   tfn_norm u_norm (
      .clock(clock), .reset(reset),
      .up_valid(cross_valid), .up_ready(cross_ready),
      .up_mag(cross_mag), .up_neg(cross_neg), .min_length_sq(ml_sq_ff),
      .dn_valid(norm_valid), .dn_ready(norm_ready),
      .dn_side(norm_side), .dn_sum(norm_sum)
   );

   tfn_isqrt u_isqrt (
      .clock(clock), .reset(reset),
      .up_valid(norm_valid), .up_ready(norm_ready),
      .up_sum(norm_sum), .up_side(norm_side),
      .dn_valid(root_valid), .dn_ready(root_ready),
      .dn_root(root), .dn_side(root_side)
   );

   tfn_div u_div (
      .clock(clock), .reset(reset),
      .up_valid(root_valid), .up_ready(root_ready),
      .up_root(root), .up_side(root_side),
      .dn_valid(div_valid), .dn_ready(div_ready),
      .dn_quot(quot), .dn_side(div_side)
   );

   // output register frees itself whenever the consumer takes the transaction
   assign out_ready = !rsp_valid_ff || rsp_tready;
   assign div_ready = out_ready;

   // saturate to one, apply sign, force zero for degenerate faces
   always_comb begin
      rsp_data_in = '0;
      qs = '0;
      comp = '0;
      for (int i = 0; i < 3; i++) begin
         qs = (quot[i] > Q_ONE) ? Q_ONE : quot[i];
         comp = NWD'(qs);
         if (div_side.neg[i]) comp = NWD'(-comp);
         if (div_side.degen) comp = '0;
         rsp_data_in[i*NWD +: NWD] = comp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && div_valid) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= div_side.degen;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_user_ff;

   // degenerate faces carry an all zero normal
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("degenerate result with nonzero normal");

   // every component stays within plus or minus one
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |->
         ($signed(rsp_tdata[0 +: NWD]) <= $signed({1'b0, Q_ONE}))
      && ($signed(rsp_tdata[0 +: NWD]) >= -$signed({1'b0, Q_ONE}))
      && ($signed(rsp_tdata[NWD +: NWD]) <= $signed({1'b0, Q_ONE}))
      && ($signed(rsp_tdata[NWD +: NWD]) >= -$signed({1'b0, Q_ONE}))
      && ($signed(rsp_tdata[2*NWD +: NWD]) <= $signed({1'b0, Q_ONE}))
      && ($signed(rsp_tdata[2*NWD +: NWD]) >= -$signed({1'b0, Q_ONE})))
      else $error("normal component out of range");

   // a threshold write lands in the register
   a_csr_write: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |=> min_length_ff == $past(csr_data))
      else $error("threshold write lost");

   // an empty output register opens the whole pipeline
   a_open: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_tready)
      else $error("input stalled with empty output");

endmodule

/* hdl/tfn_cross.sv */
// edge vectors, cross product and component magnitudes, four stages
module tfn_cross (
   input  logic clock,
   input  logic reset,
   input  logic up_valid,
   output logic up_ready,
   input  logic [8:0][tfn_pkg::COORD_WIDTH-1:0] up_coord,
   output logic dn_valid,
   input  logic dn_ready,
   output logic [2:0][tfn_pkg::CROSS_WIDTH-1:0] dn_mag,
   output logic [2:0] dn_neg
);

   localparam int STAGES = 4;

   logic [STAGES-1:0] valid_ff, valid_in, en;

   logic signed [tfn_pkg::EDGE_WIDTH-1:0]  e_ff [3], e_in [3], f_ff [3], f_in [3];
   logic signed [tfn_pkg::PROD_WIDTH-1:0]  p_ff [6], p_in [6];
   logic signed [tfn_pkg::CROSS_WIDTH-1:0] c_ff [3], c_in [3];
   logic        [tfn_pkg::CROSS_WIDTH-1:0] mag_ff [3], mag_in [3];
   logic [2:0] neg_ff, neg_in;

   always_comb begin
      en[STAGES-1] = !valid_ff[STAGES-1] || dn_ready;
      for (int k = STAGES - 2; k >= 0; k--) en[k] = !valid_ff[k] || en[k+1];
      valid_in[0] = up_valid;
      for (int k = 1; k < STAGES; k++) valid_in[k] = valid_ff[k-1];
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         e_in[i] = $signed({up_coord[3+i][tfn_pkg::COORD_WIDTH-1], up_coord[3+i]})
                 - $signed({up_coord[i][tfn_pkg::COORD_WIDTH-1], up_coord[i]});
         f_in[i] = $signed({up_coord[6+i][tfn_pkg::COORD_WIDTH-1], up_coord[6+i]})
                 - $signed({up_coord[i][tfn_pkg::COORD_WIDTH-1], up_coord[i]});
      end
      p_in[0] = e_ff[1] * f_ff[2];
      p_in[1] = e_ff[2] * f_ff[1];
      p_in[2] = e_ff[2] * f_ff[0];
      p_in[3] = e_ff[0] * f_ff[2];
      p_in[4] = e_ff[0] * f_ff[1];
      p_in[5] = e_ff[1] * f_ff[0];
      for (int i = 0; i < 3; i++) begin
         c_in[i] = tfn_pkg::CROSS_WIDTH'(p_ff[2*i]) - tfn_pkg::CROSS_WIDTH'(p_ff[2*i+1]);
         neg_in[i] = c_ff[i][tfn_pkg::CROSS_WIDTH-1];
         mag_in[i] = neg_in[i] ? tfn_pkg::CROSS_WIDTH'(-c_ff[i]) : c_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < STAGES; k++) if (en[k]) valid_ff[k] <= valid_in[k];
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         e_ff <= e_in;
         f_ff <= f_in;
      end
      if (en[1]) p_ff <= p_in;
      if (en[2]) c_ff <= c_in;
      if (en[3]) begin
         mag_ff <= mag_in;
         neg_ff <= neg_in;
      end
   end

   assign up_ready = en[0];
   assign dn_valid = valid_ff[STAGES-1];
   assign dn_neg   = neg_ff;
   always_comb for (int i = 0; i < 3; i++) dn_mag[i] = mag_ff[i];

endmodule

/* hdl/tfn_norm.sv */
// degenerate test, leading bit search, normalizing shift and sum of squares, six stages
module tfn_norm (
   input  logic clock,
   input  logic reset,
   input  logic up_valid,
   output logic up_ready,
   input  logic [2:0][tfn_pkg::CROSS_WIDTH-1:0] up_mag,
   input  logic [2:0] up_neg,
   input  logic [tfn_pkg::SQ_WIDTH-1:0] min_length_sq,
   output logic dn_valid,
   input  logic dn_ready,
   output tfn_pkg::root_side_type dn_side,
   output logic [tfn_pkg::SUM_WIDTH-1:0] dn_sum
);

   localparam int STAGES = 6;
   localparam int HW = tfn_pkg::HALF_WIDTH;
   localparam int CW = tfn_pkg::CROSS_WIDTH;
   localparam int NT = tfn_pkg::NORM_TOP_BITS;
   localparam int BW = tfn_pkg::BITLEN_WIDTH;

   logic [STAGES-1:0] valid_ff, valid_in, en;

   // stage 0
   logic [CW-1:0] mag0_ff [3], mag0_in [3];
   logic [2:0] neg0_ff;
   logic [CW-1:0] orw_ff, orw_in;
   logic zero0_ff, zero0_in, huge0_ff, huge0_in;
   logic [2*HW-1:0] hh_ff [3], hh_in [3], hl_ff [3], hl_in [3], ll_ff [3], ll_in [3];
   // stage 1
   logic [CW-1:0] mag1_ff [3];
   logic [2:0] neg1_ff;
   logic zero1_ff, huge1_ff;
   logic [3:0] lb_ff [tfn_pkg::GROUPS], lb_in [tfn_pkg::GROUPS];
   logic [tfn_pkg::SQ_WIDTH-1:0] sq_ff [3], sq_in [3];
   logic [tfn_pkg::GROUPS*8-1:0] orw_pad;
   // stage 2
   logic [CW-1:0] mag2_ff [3];
   logic [2:0] neg2_ff;
   logic [BW-1:0] top_ff, top_in;
   logic degen2_ff, degen2_in;
   logic [tfn_pkg::L2_WIDTH-1:0] l2;
   // stage 3
   logic [NT-1:0] a3_ff [3], a3_in [3];
   logic [2:0] neg3_ff;
   logic degen3_ff;
   logic [tfn_pkg::SHIFT_WIDTH-1:0] mag_ext;
   // stage 4
   logic [NT-1:0] a4_ff [3];
   logic [2:0] neg4_ff;
   logic degen4_ff;
   logic [2*NT-1:0] asq_ff [3], asq_in [3];
   // stage 5
   logic [NT-1:0] a5_ff [3];
   logic [2:0] neg5_ff;
   logic degen5_ff;
   logic [tfn_pkg::SUM_WIDTH-1:0] sum_ff, sum_in;

   always_comb begin
      en[STAGES-1] = !valid_ff[STAGES-1] || dn_ready;
      for (int k = STAGES - 2; k >= 0; k--) en[k] = !valid_ff[k] || en[k+1];
      valid_in[0] = up_valid;
      for (int k = 1; k < STAGES; k++) valid_in[k] = valid_ff[k-1];
   end

   always_comb begin
      // stage 0: or of magnitudes gives the common bit length
      orw_in = up_mag[0] | up_mag[1] | up_mag[2];
      zero0_in = (orw_in == '0);
      huge0_in = |orw_in[CW-1:tfn_pkg::MIN_LENGTH_WIDTH];
      for (int i = 0; i < 3; i++) begin
         mag0_in[i] = up_mag[i];
         hh_in[i] = up_mag[i][2*HW-1:HW] * up_mag[i][2*HW-1:HW];
         hl_in[i] = up_mag[i][2*HW-1:HW] * up_mag[i][HW-1:0];
         ll_in[i] = up_mag[i][HW-1:0] * up_mag[i][HW-1:0];
      end
      // stage 1: bit length within each byte, squares assembled
      orw_pad = (tfn_pkg::GROUPS*8)'(orw_ff);
      for (int g = 0; g < tfn_pkg::GROUPS; g++) begin
         lb_in[g] = '0;
         for (int j = 0; j < 8; j++) if (orw_pad[g*8+j]) lb_in[g] = 4'(j + 1);
      end
      for (int i = 0; i < 3; i++) begin
         sq_in[i] = (tfn_pkg::SQ_WIDTH'(hh_ff[i]) << (2*HW))
                  + (tfn_pkg::SQ_WIDTH'(hl_ff[i]) << (HW + 1))
                  + tfn_pkg::SQ_WIDTH'(ll_ff[i]);
      end
      // stage 2: highest nonzero byte, length compare
      top_in = '0;
      for (int g = 0; g < tfn_pkg::GROUPS; g++) begin
         if (lb_ff[g] != '0) top_in = BW'(g*8) + BW'(lb_ff[g]);
      end
      l2 = tfn_pkg::L2_WIDTH'(sq_ff[0]) + tfn_pkg::L2_WIDTH'(sq_ff[1])
         + tfn_pkg::L2_WIDTH'(sq_ff[2]);
      degen2_in = zero1_ff || (!huge1_ff && (l2 < tfn_pkg::L2_WIDTH'(min_length_sq)));
      // stage 3: top bit of the largest magnitude to bit NT-1
      mag_ext = '0;
      for (int i = 0; i < 3; i++) begin
         mag_ext = tfn_pkg::SHIFT_WIDTH'(mag2_ff[i]);
         if (top_ff >= BW'(NT)) a3_in[i] = NT'(mag_ext >> (top_ff - BW'(NT)));
         else a3_in[i] = NT'(mag_ext << (BW'(NT) - top_ff));
      end
      // stage 4 and 5: sum of squares
      for (int i = 0; i < 3; i++) asq_in[i] = a3_ff[i] * a3_ff[i];
      sum_in = tfn_pkg::SUM_WIDTH'(asq_ff[0]) + tfn_pkg::SUM_WIDTH'(asq_ff[1])
             + tfn_pkg::SUM_WIDTH'(asq_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < STAGES; k++) if (en[k]) valid_ff[k] <= valid_in[k];
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         mag0_ff <= mag0_in;
         neg0_ff <= up_neg;
         orw_ff <= orw_in;
         zero0_ff <= zero0_in;
         huge0_ff <= huge0_in;
         hh_ff <= hh_in;
         hl_ff <= hl_in;
         ll_ff <= ll_in;
      end
      if (en[1]) begin
         mag1_ff <= mag0_ff;
         neg1_ff <= neg0_ff;
         zero1_ff <= zero0_ff;
         huge1_ff <= huge0_ff;
         lb_ff <= lb_in;
         sq_ff <= sq_in;
      end
      if (en[2]) begin
         mag2_ff <= mag1_ff;
         neg2_ff <= neg1_ff;
         top_ff <= top_in;
         degen2_ff <= degen2_in;
      end
      if (en[3]) begin
         a3_ff <= a3_in;
         neg3_ff <= neg2_ff;
         degen3_ff <= degen2_ff;
      end
      if (en[4]) begin
         a4_ff <= a3_ff;
         neg4_ff <= neg3_ff;
         degen4_ff <= degen3_ff;
         asq_ff <= asq_in;
      end
      if (en[5]) begin
         a5_ff <= a4_ff;
         neg5_ff <= neg4_ff;
         degen5_ff <= degen4_ff;
         sum_ff <= sum_in;
      end
   end

   assign up_ready = en[0];
   assign dn_valid = valid_ff[STAGES-1];
   assign dn_sum   = sum_ff;
   always_comb begin
      for (int i = 0; i < 3; i++) dn_side.a[i] = a5_ff[i];
      dn_side.neg = neg5_ff;
      dn_side.degen = degen5_ff;
   end

endmodule

/* hdl/tfn_isqrt.sv */
// pipelined integer square root, one root bit per stage
module tfn_isqrt (
   input  logic clock,
   input  logic reset,
   input  logic up_valid,
   output logic up_ready,
   input  logic [tfn_pkg::SUM_WIDTH-1:0] up_sum,
   input  tfn_pkg::root_side_type up_side,
   output logic dn_valid,
   input  logic dn_ready,
   output logic [tfn_pkg::ROOT_WIDTH-1:0] dn_root,
   output tfn_pkg::root_side_type dn_side
);

   localparam int STAGES = tfn_pkg::ROOT_WIDTH;
   localparam int RW = tfn_pkg::REM_WIDTH;
   localparam int QW = tfn_pkg::ROOT_WIDTH;
   localparam int SW = tfn_pkg::SUM_WIDTH;

   logic [STAGES-1:0] valid_ff, valid_in, en;
   logic [RW-1:0] rem_ff [STAGES], rem_in [STAGES], rem_src [STAGES];
   logic [QW-1:0] q_ff [STAGES], q_in [STAGES], q_src [STAGES];
   logic [SW-1:0] sv_ff [STAGES], sv_in [STAGES], sv_src [STAGES];
   tfn_pkg::root_side_type side_ff [STAGES], side_src [STAGES];

   always_comb begin
      en[STAGES-1] = !valid_ff[STAGES-1] || dn_ready;
      for (int k = STAGES - 2; k >= 0; k--) en[k] = !valid_ff[k] || en[k+1];
      valid_in[0] = up_valid;
      for (int k = 1; k < STAGES; k++) valid_in[k] = valid_ff[k-1];
   end

   always_comb begin
      logic [RW-1:0] rem2;
      logic [RW-1:0] trial;
      rem_src[0] = '0;
      q_src[0] = '0;
      sv_src[0] = up_sum;
      side_src[0] = up_side;
      for (int k = 1; k < STAGES; k++) begin
         rem_src[k] = rem_ff[k-1];
         q_src[k] = q_ff[k-1];
         sv_src[k] = sv_ff[k-1];
         side_src[k] = side_ff[k-1];
      end
      for (int k = 0; k < STAGES; k++) begin
         // bring down the next two radicand bits, try root bit one
         rem2 = {rem_src[k][RW-3:0], sv_src[k][SW-1:SW-2]};
         trial = {q_src[k], 2'b01};
         if (rem2 >= trial) begin
            rem_in[k] = rem2 - trial;
            q_in[k] = {q_src[k][QW-2:0], 1'b1};
         end else begin
            rem_in[k] = rem2;
            q_in[k] = {q_src[k][QW-2:0], 1'b0};
         end
         sv_in[k] = sv_src[k] << 2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < STAGES; k++) if (en[k]) valid_ff[k] <= valid_in[k];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < STAGES; k++) begin
         if (en[k]) begin
            rem_ff[k] <= rem_in[k];
            q_ff[k] <= q_in[k];
            sv_ff[k] <= sv_in[k];
            side_ff[k] <= side_src[k];
         end
      end
   end

   assign up_ready = en[0];
   assign dn_valid = valid_ff[STAGES-1];
   assign dn_root  = q_ff[STAGES-1];
   assign dn_side  = side_ff[STAGES-1];

endmodule

/* hdl/tfn_div.sv */
// three-lane pipelined restoring divider, one quotient bit per stage
module tfn_div (
   input  logic clock,
   input  logic reset,
   input  logic up_valid,
   output logic up_ready,
   input  logic [tfn_pkg::ROOT_WIDTH-1:0] up_root,
   input  tfn_pkg::root_side_type up_side,
   output logic dn_valid,
   input  logic dn_ready,
   output logic [2:0][tfn_pkg::QUOT_WIDTH-1:0] dn_quot,
   output tfn_pkg::div_side_type dn_side
);

   localparam int STAGES = tfn_pkg::QUOT_WIDTH;
   localparam int NW = tfn_pkg::NUM_WIDTH;
   localparam int DW = tfn_pkg::DIV_WIDTH;
   localparam int QW = tfn_pkg::QUOT_WIDTH;

   logic [STAGES-1:0] valid_ff, valid_in, en;
   logic [NW-1:0] rem_ff [STAGES][3], rem_in [STAGES][3], rem_src [STAGES][3];
   logic [QW-1:0] quot_ff [STAGES][3], quot_in [STAGES][3], quot_src [STAGES][3];
   logic [DW-1:0] d_ff [STAGES], d_src [STAGES];
   tfn_pkg::div_side_type side_ff [STAGES], side_src [STAGES];

   always_comb begin
      en[STAGES-1] = !valid_ff[STAGES-1] || dn_ready;
      for (int k = STAGES - 2; k >= 0; k--) en[k] = !valid_ff[k] || en[k+1];
      valid_in[0] = up_valid;
      for (int k = 1; k < STAGES; k++) valid_in[k] = valid_ff[k-1];
   end

   always_comb begin
      logic [NW-1:0] dsh;
      // numerator a * 2^(frac+1) + r over 2r gives the rounded quotient
      for (int i = 0; i < 3; i++) begin
         rem_src[0][i] = (NW'(up_side.a[i]) << (tfn_pkg::NORMAL_FRAC_BITS + 1)) + NW'(up_root);
         quot_src[0][i] = '0;
      end
      d_src[0] = {up_root, 1'b0};
      side_src[0].neg = up_side.neg;
      side_src[0].degen = up_side.degen;
      for (int k = 1; k < STAGES; k++) begin
         rem_src[k] = rem_ff[k-1];
         quot_src[k] = quot_ff[k-1];
         d_src[k] = d_ff[k-1];
         side_src[k] = side_ff[k-1];
      end
      for (int k = 0; k < STAGES; k++) begin
         dsh = NW'(d_src[k]) << (QW - 1 - k);
         for (int i = 0; i < 3; i++) begin
            if (rem_src[k][i] >= dsh) begin
               rem_in[k][i] = rem_src[k][i] - dsh;
               quot_in[k][i] = quot_src[k][i] | (QW'(1) << (QW - 1 - k));
            end else begin
               rem_in[k][i] = rem_src[k][i];
               quot_in[k][i] = quot_src[k][i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < STAGES; k++) if (en[k]) valid_ff[k] <= valid_in[k];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < STAGES; k++) begin
         if (en[k]) begin
            rem_ff[k] <= rem_in[k];
            quot_ff[k] <= quot_in[k];
            d_ff[k] <= d_src[k];
            side_ff[k] <= side_src[k];
         end
      end
   end

   assign up_ready = en[0];
   assign dn_valid = valid_ff[STAGES-1];
   assign dn_side  = side_ff[STAGES-1];
   always_comb for (int i = 0; i < 3; i++) dn_quot[i] = quot_ff[STAGES-1][i];

endmodule
